// ===== hw/rtl/adsr_pkg.sv =====
// Shared types and constants for the linear ADSR envelope generator.
// Holds request/response structs, phase codes and register indexes.
// No dependencies.
package adsr_pkg;

  // Step counter width; the ramp product grows with it.
  localparam int unsigned StepBits    = 32;
  localparam int unsigned RateBits    = 24;
  localparam int unsigned LevelBits   = 16;
  localparam int unsigned PhaseBits   = 3;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 24;
  localparam int unsigned ProdBits    = StepBits + RateBits;

  // Release ends at or below 0.1 full scale (Q1.15).
  localparam logic [LevelBits-1:0] ReleaseEnd = 16'd3276;

  // Register reset values
  localparam logic [LevelBits-1:0] AttackPeakRst  = 16'd32768;
  localparam logic [LevelBits-1:0] SustainHoldRst = 16'd16384;

  typedef enum logic [1:0] {
    KindTick    = 2'd0,
    KindAdvance = 2'd1,
    KindForce   = 2'd2,
    KindNop     = 2'd3
  } kind_e;

  typedef enum logic [PhaseBits-1:0] {
    PhCodeIdle    = 3'd0,
    PhCodeAttack  = 3'd1,
    PhCodeDecay   = 3'd2,
    PhCodeSustain = 3'd3,
    PhCodeRelease = 3'd4,
    PhCodeDone    = 3'd5
  } phase_code_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgAttackRate  = 3'd0,
    CfgAttackPeak  = 3'd1,
    CfgDecayRate   = 3'd2,
    CfgSustainHold = 3'd3,
    CfgReleaseRate = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    kind_e                kind;
    logic [PhaseBits-1:0] forced_phase;
  } in_req_t;

  typedef struct packed {
    logic [LevelBits-1:0] level;
    logic [PhaseBits-1:0] phase_now;
  } out_rsp_t;

endpackage

// ===== hw/rtl/adsr_envelope_generator_core.sv =====
// Linear ADSR envelope generator, top level.
// Depends on adsr_pkg (types, phase codes, register indexes).
//
// Usage:
//   in_*   : one request per item: tick, advance a phase, force phase or no-op.
//   out_*  : one response per request: level (Q1.15) and phase after the item.
//   cfg_*  : register writes (index + data); always ready. Registers must be
//   written only while idle; the user ensures this, the block does not check.
// Throughput: one request per cycle while out_ready_i is high. The request
//   register and the response register sit around one combinational pass:
//   a 32x24 ramp multiply, one subtract/clamp, one compare to the phase target.
// Reset: phase idle, step count, level and release start cleared; registers
//   take their reset values (rates 0, attack peak 1.0, sustain 0.5).
// Stall: while out_ready_i is low the response register holds; the request
//   register still takes one more request, then in_ready_o drops until the
//   response is taken. No request is dropped or repeated.
module adsr_envelope_generator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  adsr_pkg::in_req_t                 in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output adsr_pkg::out_rsp_t                out_rsp_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [adsr_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [adsr_pkg::CfgDataBits-1:0]  cfg_data_i
);
  import adsr_pkg::*;

  // One-hot phase state
  typedef enum logic [5:0] {
    PhIdle    = 6'b000001,
    PhAttack  = 6'b000010,
    PhDecay   = 6'b000100,
    PhSustain = 6'b001000,
    PhRelease = 6'b010000,
    PhDone    = 6'b100000
  } phase_e;

  function automatic phase_e phase_next(input phase_e p);
    phase_e r;
    unique case (p)
      PhIdle:    r = PhAttack;
      PhAttack:  r = PhDecay;
      PhDecay:   r = PhSustain;
      PhSustain: r = PhRelease;
      default:   r = PhDone;
    endcase
    return r;
  endfunction

  // Codes above done map to done
  function automatic phase_e phase_decode(input logic [PhaseBits-1:0] c);
    phase_e r;
    unique case (phase_code_e'(c))
      PhCodeIdle:    r = PhIdle;
      PhCodeAttack:  r = PhAttack;
      PhCodeDecay:   r = PhDecay;
      PhCodeSustain: r = PhSustain;
      PhCodeRelease: r = PhRelease;
      default:       r = PhDone;
    endcase
    return r;
  endfunction

  function automatic logic [PhaseBits-1:0] phase_encode(input phase_e p);
    phase_code_e r;
    unique case (p)
      PhIdle:    r = PhCodeIdle;
      PhAttack:  r = PhCodeAttack;
      PhDecay:   r = PhCodeDecay;
      PhSustain: r = PhCodeSustain;
      PhRelease: r = PhCodeRelease;
      default:   r = PhCodeDone;
    endcase
    return r;
  endfunction

  // ---------------- configuration registers ----------------
  logic [RateBits-1:0]  attack_rate_q, decay_rate_q, release_rate_q;
  logic [LevelBits-1:0] attack_peak_q, sustain_hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_rate_q  <= '0;
      attack_peak_q  <= AttackPeakRst;
      decay_rate_q   <= '0;
      sustain_hold_q <= SustainHoldRst;
      release_rate_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgAttackRate:  attack_rate_q  <= cfg_data_i[RateBits-1:0];
        CfgAttackPeak:  attack_peak_q  <= cfg_data_i[LevelBits-1:0];
        CfgDecayRate:   decay_rate_q   <= cfg_data_i[RateBits-1:0];
        CfgSustainHold: sustain_hold_q <= cfg_data_i[LevelBits-1:0];
        CfgReleaseRate: release_rate_q <= cfg_data_i[RateBits-1:0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  // ---------------- request register ----------------
  logic    in_valid_q;
  in_req_t in_req_q;
  logic    out_valid_q;
  logic    fire;

  // Request is processed when the response register is free or draining
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
  end

  // ---------------- envelope state ----------------
  phase_e               phase_q, phase_d;
  logic [StepBits-1:0]  step_q, step_d;
  logic [LevelBits-1:0] level_q, level_d;
  logic [LevelBits-1:0] rstart_q, rstart_d;

  logic [StepBits-1:0]  step_inc;
  logic [RateBits-1:0]  rate_sel;
  logic [ProdBits-1:0]  prod;
  logic [LevelBits-1:0] ramp;
  logic [LevelBits-1:0] fall_start;
  logic [LevelBits-1:0] fall;

  // Saturating step increment
  assign step_inc = (&step_q) ? step_q : step_q + 1'b1;

  always_comb begin
    unique case (phase_q)
      PhAttack:  rate_sel = attack_rate_q;
      PhDecay:   rate_sel = decay_rate_q;
      PhRelease: rate_sel = release_rate_q;
      default:   rate_sel = '0;
    endcase
  end

  // Ramp in Q1.15: product >> 16, saturated to the level width
  assign prod = ProdBits'(step_inc) * ProdBits'(rate_sel);
  assign ramp = (|prod[ProdBits-1:2*LevelBits]) ? '1 : prod[2*LevelBits-1:LevelBits];

  assign fall_start = (phase_q == PhDecay) ? attack_peak_q : rstart_q;
  assign fall       = (ramp >= fall_start) ? '0 : fall_start - ramp;

  always_comb begin
    phase_d  = phase_q;
    step_d   = step_q;
    level_d  = level_q;
    rstart_d = rstart_q;
    unique case (in_req_q.kind)
      KindTick: begin
        step_d = step_inc;
        unique case (phase_q)
          PhAttack: begin
            if (attack_rate_q == '0) begin
              level_d = attack_peak_q;
              phase_d = PhDecay;
              step_d  = '0;
            end else begin
              level_d = ramp;
              if (ramp >= attack_peak_q) begin
                phase_d = PhDecay;
                step_d  = '0;
              end
            end
            rstart_d = level_d;
          end
          PhDecay: begin
            if (decay_rate_q == '0) begin
              level_d = sustain_hold_q;
              phase_d = PhSustain;
              step_d  = '0;
            end else begin
              level_d = fall;
              if (fall <= sustain_hold_q) begin
                phase_d = PhSustain;
                step_d  = '0;
              end
            end
            rstart_d = level_d;
          end
          PhSustain: begin
            level_d  = sustain_hold_q;
            rstart_d = sustain_hold_q;
            if (sustain_hold_q == '0) begin
              phase_d = PhDone;
              step_d  = '0;
            end
          end
          PhRelease: begin
            if (release_rate_q == '0) begin
              level_d = '0;
              phase_d = PhDone;
              step_d  = '0;
            end else begin
              level_d = fall;
              if (fall <= ReleaseEnd) begin
                phase_d = PhDone;
                step_d  = '0;
              end
            end
          end
          default: ; // idle and done hold the level
        endcase
      end
      KindAdvance: begin
        // done does not advance; its step count is left alone
        if (phase_q != PhDone) begin
          phase_d = phase_next(phase_q);
          step_d  = '0;
        end
      end
      KindForce: begin
        phase_d = phase_decode(in_req_q.forced_phase);
        step_d  = '0;
      end
      default: ; // no-op request
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      step_q   <= '0;
      level_q  <= '0;
      rstart_q <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      step_q   <= step_d;
      level_q  <= level_d;
      rstart_q <= rstart_d;
    end
  end

  // ---------------- response register ----------------
  out_rsp_t out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rsp_q.level     <= level_d;
      out_rsp_q.phase_now <= phase_encode(phase_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== hw/rtl/adsr_checker.sv =====
// Port-level checker for the ADSR envelope generator, bound to the top level.
// Depends on adsr_pkg (phase codes, response struct).
module adsr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input adsr_pkg::out_rsp_t out_rsp_o
);
  import adsr_pkg::*;

  logic                 have_prev_q;
  logic [LevelBits-1:0] prev_level_q;
  logic [PhaseBits-1:0] prev_phase_q;
  logic                 out_acc;
  logic                 prev_quiet;

  assign out_acc    = out_valid_o && out_ready_i;
  assign prev_quiet = have_prev_q &&
                      (prev_phase_q == PhCodeIdle || prev_phase_q == PhCodeDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else if (out_acc) begin
      have_prev_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      prev_level_q <= out_rsp_o.level;
      prev_phase_q <= out_rsp_o.phase_now;
    end
  end

  // A pending response holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response dropped or changed while stalled");

  // Reported phase is always a defined code
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.phase_now <= PhCodeDone)
    else $error("phase code out of range");

  // Nothing can move the level out of idle or done
  a_quiet_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && prev_quiet |-> out_rsp_o.level == prev_level_q)
    else $error("level changed after idle or done");

  // With the response register empty the block always takes a request
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty response register");

  // Every accepted request leads to a valid response from the response register
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 out_valid_o)
    else $error("accepted request produced no response");

endmodule

bind adsr_envelope_generator_core adsr_checker u_adsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
